// ===== hdl/kpi_pkg.sv =====
package kpi_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int POS_W         = 32;
    localparam int SLOT_W        = 6;
    localparam int BLEND_W       = 17;
    localparam int COUNT_W       = 7;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [SLOT_W-1:0]        key_slot;
        logic [TIME_W-1:0]        sample_time;
        logic signed [POS_W-1:0]  value_x;
        logic signed [POS_W-1:0]  value_y;
        logic signed [POS_W-1:0]  value_z;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [SLOT_W-1:0]        base_key;
        logic [BLEND_W-1:0]       blend;
    } out_item_t;

    // control handed from sequencer to the divider cell row
    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

endpackage

// ===== hdl/kpi_if.sv =====
interface kpi_in_if;
    import kpi_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface kpi_out_if;
    import kpi_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// ===== hdl/kpi_div_cell.sv =====
// One restoring-division cell: takes partial remainder and quotient from its
// left neighbour, does one subtract-compare step, hands the result on.
module kpi_div_cell #(
    parameter int W = 49
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_rem,
    input  logic [W-1:0] in_num,
    input  logic [W-1:0] in_quo,
    input  logic [W-1:0] den,
    output logic         out_valid,
    output logic [W-1:0] out_rem,
    output logic [W-1:0] out_num,
    output logic [W-1:0] out_quo
);
    logic [W-1:0] rem_sh;
    logic         take;
    logic         valid_reg;
    logic [W-1:0] rem_reg, num_reg, quo_reg;

    // shift in next numerator bit and try the subtract
    always_comb
    begin
        rem_sh = {in_rem[W-2:0], in_num[W-1]};
        take   = (rem_sh >= den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= take ? (rem_sh - den) : rem_sh;
        num_reg <= {in_num[W-2:0], 1'b0};
        quo_reg <= {in_quo[W-2:0], take};
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
endmodule

// ===== hdl/kpi_divider.sv =====
// Row of division cells; the denominator is held steady by the sequencer.
module kpi_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          off,
    input  logic [31:0]          span,
    output logic                 done,
    output logic [FRAC_BITS:0]   quo
);
    localparam int W = 32 + FRAC_BITS + 1;
    localparam int N = W;

    logic [W-1:0] rem_a [0:N];
    logic [W-1:0] num_a [0:N];
    logic [W-1:0] quo_a [0:N];
    logic         vld_a [0:N];
    logic [W-1:0] den;

    assign den      = {{(FRAC_BITS+1){1'b0}}, span};
    assign rem_a[0] = '0;
    assign num_a[0] = {1'b0, off, {FRAC_BITS{1'b0}}};
    assign quo_a[0] = '0;
    assign vld_a[0] = start;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            kpi_div_cell #(.W(W)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .in_valid(vld_a[g]), .in_rem(rem_a[g]), .in_num(num_a[g]),
                .in_quo(quo_a[g]), .den(den),
                .out_valid(vld_a[g+1]), .out_rem(rem_a[g+1]),
                .out_num(num_a[g+1]), .out_quo(quo_a[g+1])
            );
        end
    endgenerate

    assign done = vld_a[N];
    assign quo  = quo_a[N][FRAC_BITS:0];
endmodule

// ===== hdl/keyframe_position_interpolator_unit.sv =====
// Sequence: a sample's keys are searched (S_RD, S_CMP), the interval's times read (S_T0, S_T1,
//   S_FR), the fraction checked and divided in the cell row when needed, then each axis blended
//   (S_AX, S_MUL, S_ADD, S_OUT); a single key skips search and fraction. Loads give no result.
// Throughput: one sample in flight; loads are taken one per cycle while idle, the next item is
//   taken from the cycle the result is raised, and a held result stalls it at its first output.
// Reset: rst_n asynchronous active low clears control, sets key_count to 1; table undefined.
module keyframe_position_interpolator_unit
#(
    parameter int MAX_KEYS  = kpi_pkg::MAX_KEYS_DEF,
    parameter int FRAC_BITS = kpi_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    kpi_in_if.sink                    in_ch,
    kpi_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [kpi_pkg::COUNT_W-1:0] cfg_wdata
);
    import kpi_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = AW + 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CMP = 4'd2, S_T0 = 4'd3,
                           S_T1 = 4'd4, S_FR = 4'd5, S_DIV = 4'd6, S_AX = 4'd7,
                           S_MUL = 4'd8, S_ADD = 4'd9, S_OUT = 4'd10, S_CHK = 4'd11;

    logic [TIME_W-1:0] t_mem [0:MAX_KEYS-1];
    logic [POS_W-1:0]  x_mem [0:MAX_KEYS-1];
    logic [POS_W-1:0]  y_mem [0:MAX_KEYS-1];
    logic [POS_W-1:0]  z_mem [0:MAX_KEYS-1];

    logic [COUNT_W-1:0] count_reg;
    logic [3:0]         state_reg;
    logic [TIME_W-1:0]  q_reg, t_rd_reg, t0_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      k_reg;
    logic [CW-1:0]      n_eff;
    logic [FRAC_BITS:0] blend_reg;
    logic [1:0]         ax_reg;
    logic signed [POS_W-1:0] p0_reg, p0_rd_reg, p1_rd_reg;
    logic signed [POS_W:0]   diff_reg;
    logic signed [POS_W+FRAC_BITS+2:0] prod_reg;
    logic               single_reg;
    logic               div_start;
    logic               div_done;
    logic [FRAC_BITS:0] div_quo;
    logic [TIME_W-1:0]  off_reg, span_reg;
    out_item_t          res_reg;
    logic               ovalid_reg;

    // effective key count, clamped to 1..MAX_KEYS
    always_comb
    begin
        if (count_reg == '0)
            n_eff = CW'(1);
        else if (32'(count_reg) > MAX_KEYS)
            n_eff = CW'(MAX_KEYS);
        else
            n_eff = CW'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= COUNT_W'(1);
        else if (cfg_we)
            count_reg <= cfg_wdata;
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    // table write and registered reads
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.data.kind == KIND_LOAD
            && 32'(in_ch.data.key_slot) < MAX_KEYS)
        begin
            t_mem[AW'(in_ch.data.key_slot)] <= in_ch.data.sample_time;
            x_mem[AW'(in_ch.data.key_slot)] <= in_ch.data.value_x;
            y_mem[AW'(in_ch.data.key_slot)] <= in_ch.data.value_y;
            z_mem[AW'(in_ch.data.key_slot)] <= in_ch.data.value_z;
        end
        t_rd_reg <= t_mem[addr_reg];
        case (ax_reg)
            2'd0:    p0_rd_reg <= x_mem[addr_reg];
            2'd1:    p0_rd_reg <= y_mem[addr_reg];
            default: p0_rd_reg <= z_mem[addr_reg];
        endcase
        case (ax_reg)
            2'd0:    p1_rd_reg <= x_mem[AW'(addr_reg + AW'(1))];
            2'd1:    p1_rd_reg <= y_mem[AW'(addr_reg + AW'(1))];
            default: p1_rd_reg <= z_mem[AW'(addr_reg + AW'(1))];
        endcase
    end

    assign div_start = (state_reg == S_CHK) && (span_reg != '0) && (off_reg < span_reg);

    kpi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .off(off_reg), .span(span_reg), .done(div_done), .quo(div_quo)
    );

    // sequencer: search, fraction, per-axis blend
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            addr_reg   <= '0;
            ax_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.data.kind == KIND_SAMPLE)
                    begin
                        q_reg      <= in_ch.data.sample_time;
                        k_reg      <= '0;
                        single_reg <= (n_eff == CW'(1));
                        addr_reg   <= (n_eff == CW'(1)) ? AW'(0) : AW'(1);
                        blend_reg  <= '0;
                        ax_reg     <= 2'd0;
                        state_reg  <= (n_eff == CW'(1)) ? S_AX : S_RD;
                    end
                end
                S_RD: state_reg <= S_CMP;
                S_CMP:
                begin
                    // t_rd holds time of key k+1
                    if (q_reg < t_rd_reg || CW'(k_reg) + CW'(2) >= n_eff)
                    begin
                        if (!(q_reg < t_rd_reg))
                            k_reg <= '0;
                        addr_reg  <= (q_reg < t_rd_reg) ? k_reg : AW'(0);
                        state_reg <= S_T0;
                    end
                    else
                    begin
                        k_reg     <= AW'(k_reg + AW'(1));
                        addr_reg  <= AW'(addr_reg + AW'(1));
                        state_reg <= S_RD;
                    end
                end
                S_T0:
                begin
                    addr_reg  <= AW'(addr_reg + AW'(1));
                    state_reg <= S_T1;
                end
                S_T1:
                begin
                    t0_reg    <= t_rd_reg;
                    addr_reg  <= k_reg;
                    state_reg <= S_FR;
                end
                S_FR:
                begin
                    // t_rd now is t1; span is registered here
                    if (!(t_rd_reg > t0_reg && q_reg > t0_reg))
                        state_reg <= S_AX;
                    else
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (off_reg >= span_reg)
                    begin
                        blend_reg <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                        state_reg <= S_AX;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        blend_reg <= div_quo;
                        state_reg <= S_AX;
                    end
                end
                S_AX: state_reg <= S_MUL;
                S_MUL:
                begin
                    p0_reg    <= p0_rd_reg;
                    diff_reg  <= (POS_W+1)'(p1_rd_reg) - (POS_W+1)'(p0_rd_reg);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    prod_reg <= (POS_W+FRAC_BITS+3)'(diff_reg) * $signed({1'b0, blend_reg})
                                + ((POS_W+FRAC_BITS+3)'(1) <<< (FRAC_BITS-1));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        case (ax_reg)
                            2'd0:    res_reg.pos_x <= single_reg ? p0_reg
                                         : POS_W'(p0_reg + POS_W'(prod_reg >>> FRAC_BITS));
                            2'd1:    res_reg.pos_y <= single_reg ? p0_reg
                                         : POS_W'(p0_reg + POS_W'(prod_reg >>> FRAC_BITS));
                            default: res_reg.pos_z <= single_reg ? p0_reg
                                         : POS_W'(p0_reg + POS_W'(prod_reg >>> FRAC_BITS));
                        endcase
                        if (ax_reg == 2'd2)
                        begin
                            res_reg.base_key <= SLOT_W'(k_reg);
                            res_reg.blend    <= BLEND_W'(blend_reg);
                            ovalid_reg       <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_AX;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // fraction operands: offset from t0, span once t1 is read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_T1)
            off_reg <= q_reg - t_rd_reg;
        if (state_reg == S_FR)
            span_reg <= t_rd_reg - t0_reg;
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;

    // input only taken while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside wait");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ch.ready) |=> $stable(res_reg))
        else $error("result changed while held");
endmodule

// ===== sim/kpi_checker.sv =====
module kpi_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    kpi_in_if.monitor                   in_mon,
    kpi_out_if.monitor                  out_mon,
    input  logic                        cfg_we,
    input  logic [kpi_pkg::COUNT_W-1:0] cfg_wdata,
    output int                          fail_count,
    output int                          pending_count
);
    import kpi_pkg::*;

    localparam int RING_DEPTH = 64;

    // shadow of the keyframe table and key count
    logic [TIME_W-1:0]       tbl_time [MAX_KEYS_DEF];
    logic signed [POS_W-1:0] tbl_x [MAX_KEYS_DEF];
    logic signed [POS_W-1:0] tbl_y [MAX_KEYS_DEF];
    logic signed [POS_W-1:0] tbl_z [MAX_KEYS_DEF];
    logic [COUNT_W-1:0]      keys_in_use;
    out_item_t               exp_ring [RING_DEPTH];
    int                      wr_idx;
    int                      rd_idx;

    assign pending_count = wr_idx - rd_idx;

    // rounded lerp, ties toward plus infinity
    function automatic logic signed [POS_W-1:0] lerp_axis_pred(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b,
        input logic [BLEND_W-1:0]      f
    );
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(f) + (64'sd1 <<< (FRAC_BITS_DEF - 1));
        return POS_W'(longint'(a) + (prod >>> FRAC_BITS_DEF));
    endfunction

    function automatic out_item_t sample_position(input logic [TIME_W-1:0] t);
        out_item_t r;
        int n;
        int base;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic [63:0] span;
        logic [63:0] off;
        r = '0;
        n = keys_in_use;
        if (n == 0) n = 1;
        if (n > MAX_KEYS_DEF) n = MAX_KEYS_DEF;
        base = 0;
        if (n == 1)
        begin
            r.pos_x = tbl_x[0];
            r.pos_y = tbl_y[0];
            r.pos_z = tbl_z[0];
            return r;
        end
        for (int k = 0; k + 1 < n; k++)
        begin
            if (t < tbl_time[k+1])
            begin
                base = k;
                break;
            end
        end
        t0 = tbl_time[base];
        t1 = tbl_time[base+1];
        if (t1 > t0 && t > t0)
        begin
            span = 64'(t1 - t0);
            off  = 64'(t - t0);
            if (off >= span)
                r.blend = BLEND_W'(1 << FRAC_BITS_DEF);
            else
                r.blend = BLEND_W'((off << FRAC_BITS_DEF) / span);
        end
        r.base_key = SLOT_W'(base);
        r.pos_x = lerp_axis_pred(tbl_x[base], tbl_x[base+1], r.blend);
        r.pos_y = lerp_axis_pred(tbl_y[base], tbl_y[base+1], r.blend);
        r.pos_z = lerp_axis_pred(tbl_z[base], tbl_z[base+1], r.blend);
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
        begin
            keys_in_use <= COUNT_W'(1);
            wr_idx      <= 0;
            rd_idx      <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_we)
                keys_in_use <= cfg_wdata;
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.data.kind == KIND_LOAD)
                begin
                    tbl_time[in_mon.data.key_slot] <= in_mon.data.sample_time;
                    tbl_x[in_mon.data.key_slot]    <= in_mon.data.value_x;
                    tbl_y[in_mon.data.key_slot]    <= in_mon.data.value_y;
                    tbl_z[in_mon.data.key_slot]    <= in_mon.data.value_z;
                end
                else
                begin
                    exp_ring[wr_idx % RING_DEPTH] <= sample_position(in_mon.data.sample_time);
                    wr_idx <= wr_idx + 1;
                end
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (wr_idx == rd_idx)
                begin
                    $error("unexpected result item");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_item = exp_ring[rd_idx % RING_DEPTH];
                    rd_idx <= rd_idx + 1;
                    if (exp_item != out_mon.data)
                    begin
                        fail_count <= fail_count + 1;
                        if (exp_item.pos_x != out_mon.data.pos_x)
                            $error("pos_x exp %0d got %0d", exp_item.pos_x, out_mon.data.pos_x);
                        if (exp_item.pos_y != out_mon.data.pos_y)
                            $error("pos_y exp %0d got %0d", exp_item.pos_y, out_mon.data.pos_y);
                        if (exp_item.pos_z != out_mon.data.pos_z)
                            $error("pos_z exp %0d got %0d", exp_item.pos_z, out_mon.data.pos_z);
                        if (exp_item.base_key != out_mon.data.base_key)
                            $error("base_key exp %0d got %0d", exp_item.base_key,
                                   out_mon.data.base_key);
                        if (exp_item.blend != out_mon.data.blend)
                            $error("blend exp %0d got %0d", exp_item.blend, out_mon.data.blend);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_keyframe_position_interpolator_unit.sv =====
module tb_keyframe_position_interpolator_unit;
    import kpi_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending_count;
    int                 burst_left;
    int                 stall_phase;
    int                 stall_len;

    kpi_in_if  in_ch ();
    kpi_out_if out_ch ();

    keyframe_position_interpolator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    kpi_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch.monitor),
        .out_mon       (out_ch.monitor),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stall pattern: runs of ready, runs of stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase  <= 0;
            stall_len    <= 4;
        end
        else if (stall_phase >= stall_len)
        begin
            stall_phase  <= 0;
            stall_len    <= $urandom_range(1, 12);
            out_ch.ready <= ($urandom_range(0, 3) != 0) ? ~out_ch.ready : 1'b1;
        end
        else
            stall_phase <= stall_phase + 1;
    end

    // send one item, idling between bursts
    task automatic send_item(input in_item_t item);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic load_key(input int slot, input logic [31:0] t,
                            input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        in_item_t item;
        item.kind = KIND_LOAD;
        item.key_slot = SLOT_W'(slot);
        item.sample_time = t;
        item.value_x = x;
        item.value_y = y;
        item.value_z = z;
        send_item(item);
    endtask

    task automatic sample_at(input logic [31:0] t);
        in_item_t item;
        item.kind        = KIND_SAMPLE;
        item.key_slot    = SLOT_W'($urandom);
        item.sample_time = t;
        item.value_x     = $urandom;
        item.value_y     = $urandom;
        item.value_z     = $urandom;
        send_item(item);
    endtask

    // drain, then write key_count while idle
    task automatic set_key_count(input logic [COUNT_W-1:0] n);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // full table with random positions; times sorted in modes 0 and 1, random otherwise
    task automatic load_table(input int mode);
        logic [31:0] t;
        t = (mode == 0) ? 32'd0 : $urandom_range(0, 1000);
        for (int s = 0; s < MAX_KEYS_DEF; s++)
        begin
            case (mode)
                0: t = 32'(s) * 32'h0400_0000;
                1: t = t + $urandom_range(0, 3) * $urandom_range(0, 70000);
                default: t = $urandom;
            endcase
            load_key(s, t, $urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 64) * 32'h0400_0000 + $urandom_range(0, 3) - 1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [COUNT_W-1:0] n;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        burst_left  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, single key, zero and reversed interval
        load_key(0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        sample_at(32'h0);
        sample_at(32'hFFFF_FFFF);
        load_key(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        load_key(2, 32'h0001_0000, 32'h1, 32'h2, 32'h3);
        set_key_count(7'd2);
        sample_at(32'h0);
        sample_at(32'h7FFF_FFFF);
        sample_at(32'hFFFF_FFFE);
        sample_at(32'hFFFF_FFFF);
        set_key_count(7'd3);
        sample_at(32'h0000_8000);
        sample_at(32'hFFFF_FFFF);
        load_key(1, 32'h0, 32'h10, 32'h20, 32'h30);
        sample_at(32'h0);
        sample_at(32'h5);
        set_key_count(7'd0);
        sample_at(32'h1234_5678);

        // random phases over several key counts, extremes included
        for (int phase = 0; phase < 12; phase++)
        begin
            set_key_count(7'd1);
            load_table(phase % 3);
            case (phase)
                0: n = 7'd64;
                1: n = 7'd127;
                2: n = 7'd0;
                3: n = 7'd2;
                default: n = 7'($urandom_range(1, 127));
            endcase
            set_key_count(n);
            for (int k = 0; k < 80; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_key($urandom_range(0, 63), pick_time(), $urandom, $urandom, $urandom);
                else
                    sample_at(pick_time());
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("keyframe_position_interpolator_unit verification clean");
        else
            $display("keyframe_position_interpolator_unit verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("keyframe_position_interpolator_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/kpi_pkg.sv
hdl/kpi_if.sv
hdl/kpi_div_cell.sv
hdl/kpi_divider.sv
hdl/keyframe_position_interpolator_unit.sv
sim/kpi_checker.sv
sim/tb_keyframe_position_interpolator_unit.sv
